// ===== rtl/sdrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrm_pkg: shared types and codes for the signed rounding divider
// Rounding mode codes, error codes and their field widths.
// ----------------------------------------------------------------------------
package sdrm_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned ERR_W  = 2;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [ERR_W-1:0]  err_t;

  // rounding modes; unused codes behave as truncation
  localparam mode_t MODE_TRUNC   = 3'd0;
  localparam mode_t MODE_FLOOR   = 3'd1;
  localparam mode_t MODE_EUCLID  = 3'd2;
  localparam mode_t MODE_NONPOS  = 3'd3;
  localparam mode_t MODE_NEAREST = 3'd4;

  // error codes
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_DIV_ZERO = 2'd1;
  localparam err_t ERR_OVERFLOW = 2'd2;

endpackage

// ===== rtl/signed_divider_rounding_modes_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_divider_rounding_modes_core: pipelined signed divider
// Signed quotient and remainder with five selectable rounding modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: dividend and divisor, taken when in_valid is high and
//   in_stall is low. Output beat: quotient, remainder and error_code, taken
//   when out_valid is high and out_stall is low. One result per input beat,
//   in order.
//   rounding_mode is written when rounding_mode_we is high; change it only
//   while no beat is in flight. Codes 5..7 act as truncation.
//   Stages: one magnitude/flag stage, one restoring subtract per quotient
//   bit (DATA_WIDTH stages), one rounding-decision stage and the output
//   register.
//   Throughput: one beat per cycle while out_stall is low. Each stage
//   advances when it is empty or the stage after it advances, so bubbles
//   close up under a stall and new beats keep entering until every stage
//   holds one.
//   A zero divisor gives error_code 1, the minimum dividend over -1 gives
//   error_code 2; both return zero quotient and remainder.
//   Reset (rst, synchronous) empties the pipeline and sets truncation mode.
// ----------------------------------------------------------------------------
module signed_divider_rounding_modes_core
  import sdrm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         rounding_mode_we,
  input  logic [MODE_W-1:0]            rounding_mode,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic signed [DATA_WIDTH-1:0] remainder,
  output logic [ERR_W-1:0]             error_code
);

  localparam int unsigned W   = DATA_WIDTH;
  // stages: 0 prep, 1..W divide, W+1 rounding decision, W+2 output
  localparam int unsigned NS  = W + 3;
  localparam int unsigned FIX = W + 1;
  localparam int unsigned OUT = W + 2;

  mode_t mode;

  logic [NS-1:0] v;
  logic [NS:0]   adv;

  // divide stage payload, index 0 is the prep stage
  logic [W-1:0] rem_q [0:W];
  logic [W-1:0] quo_q [0:W];
  logic [W-1:0] mb_q  [0:W];
  logic [W-1:0] b_q   [0:W];
  logic         na_q  [0:W];
  logic         nb_q  [0:W];
  err_t         err_q [0:W];

  logic [W-1:0] rem_next [1:W];
  logic [W-1:0] quo_next [1:W];

  // rounding decision stage
  logic [W-1:0] fq, fr, fb;
  logic         finc, fdec;
  err_t         ferr;

  // ---------------------------------------------------------------------------
  // config register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TRUNC;
    end else if (rounding_mode_we) begin
      mode <= rounding_mode;
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: a stage moves when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  assign adv[NS] = ~out_stall;
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_adv
      assign adv[gi] = ~v[gi] | adv[gi+1];
    end
  endgenerate

  assign in_stall  = ~adv[0];
  assign out_valid = v[OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // prep stage: magnitudes, signs, error detection
  // ---------------------------------------------------------------------------
  logic         in_na, in_nb;
  logic [W-1:0] in_ma, in_mb;
  err_t         in_err;

  always_comb begin
    in_na = dividend[W-1];
    in_nb = divisor[W-1];
    in_ma = in_na ? (W'(0) - W'(dividend)) : W'(dividend);
    in_mb = in_nb ? (W'(0) - W'(divisor))  : W'(divisor);
    if (divisor == '0) begin
      in_err = ERR_DIV_ZERO;
    end else if ((dividend == {1'b1, {(W-1){1'b0}}}) && (divisor == {W{1'b1}})) begin
      in_err = ERR_OVERFLOW;
    end else begin
      in_err = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      rem_q[0] <= '0;
      quo_q[0] <= in_ma;
      mb_q[0]  <= in_mb;
      b_q[0]   <= divisor;
      na_q[0]  <= in_na;
      nb_q[0]  <= in_nb;
      err_q[0] <= in_err;
    end
  end

  // ---------------------------------------------------------------------------
  // restoring divide, one quotient bit per stage
  // ---------------------------------------------------------------------------
  generate
    for (gi = 1; gi <= W; gi++) begin : g_div
      logic [W:0] sh, diff;

      always_comb begin
        sh   = {rem_q[gi-1], quo_q[gi-1][W-1]};
        diff = sh - {1'b0, mb_q[gi-1]};
        rem_next[gi] = diff[W] ? sh[W-1:0] : diff[W-1:0];
        quo_next[gi] = {quo_q[gi-1][W-2:0], ~diff[W]};
      end

      always_ff @(posedge clk) begin
        if (adv[gi] && v[gi-1]) begin
          rem_q[gi] <= rem_next[gi];
          quo_q[gi] <= quo_next[gi];
          mb_q[gi]  <= mb_q[gi-1];
          b_q[gi]   <= b_q[gi-1];
          na_q[gi]  <= na_q[gi-1];
          nb_q[gi]  <= nb_q[gi-1];
          err_q[gi] <= err_q[gi-1];
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // rounding decision: signed truncated result plus a +1 / -1 correction
  // ---------------------------------------------------------------------------
  logic [W-1:0] qt, rt, rm, mb;
  logic         na, nb, rm_nz, adj, inc, dec;
  logic [W:0]   rm2;

  always_comb begin
    rm    = rem_q[W];
    mb    = mb_q[W];
    na    = na_q[W];
    nb    = nb_q[W];
    qt    = (na != nb) ? (W'(0) - quo_q[W]) : quo_q[W];
    rt    = na ? (W'(0) - rm) : rm;
    rm_nz = (rm != '0);
    adj   = rm_nz && (na != nb);
    rm2   = {rm, 1'b0};
    inc   = 1'b0;
    dec   = 1'b0;
    case (mode)
      MODE_TRUNC: begin
      end
      MODE_FLOOR: begin
        dec = adj;
      end
      MODE_EUCLID: begin
        if (rm_nz && na) begin
          inc = nb;
          dec = ~nb;
        end
      end
      MODE_NONPOS: begin
        if (rm_nz && !na) begin
          inc = ~nb;
          dec = nb;
        end
      end
      MODE_NEAREST: begin
        // floor first; then round up when twice the floor remainder
        // magnitude exceeds the divisor magnitude
        dec = adj;
        inc = adj ? ({1'b0, mb} > rm2) : (rm2 > {1'b0, mb});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[FIX] && v[W]) begin
      fq   <= qt;
      fr   <= rt;
      fb   <= b_q[W];
      finc <= inc;
      fdec <= dec;
      ferr <= err_q[W];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [W-1:0] q_next, r_next;

  always_comb begin
    case ({finc, fdec})
      2'b10: begin
        q_next = fq + W'(1);
        r_next = fr - fb;
      end
      2'b01: begin
        q_next = fq - W'(1);
        r_next = fr + fb;
      end
      default: begin
        q_next = fq;
        r_next = fr;
      end
    endcase
    if (ferr != ERR_NONE) begin
      q_next = '0;
      r_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT] && v[FIX]) begin
      quotient   <= q_next;
      remainder  <= r_next;
      error_code <= ferr;
    end
  end

endmodule

// ===== rtl/sdrm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrm_checker: port-level checks for the signed rounding divider
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module sdrm_checker
  import sdrm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] quotient,
  input logic [DATA_WIDTH-1:0] remainder,
  input logic [ERR_W-1:0]      error_code
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // input only backs up when the output is full and stalled
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output beat");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code == ERR_NONE || error_code == ERR_DIV_ZERO ||
                   error_code == ERR_OVERFLOW))
    else $error("unknown error_code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_NONE) |-> (quotient == '0 && remainder == '0))
    else $error("nonzero result on error beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(quotient) &&
                                  $stable(remainder) && $stable(error_code)))
    else $error("stalled output beat changed");

endmodule

bind signed_divider_rounding_modes_core sdrm_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_sdrm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .quotient   (quotient),
  .remainder  (remainder),
  .error_code (error_code)
);

// ===== dv/sdrm_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrm_result_checker: result checker for the signed rounding divider
// Snoops the operand and result channels. It predicts each quotient,
// remainder and error code under the tracked rounding mode and compares
// them in order. It reports the open expectations and the failure count.
// ----------------------------------------------------------------------------
module sdrm_result_checker
  import sdrm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rounding_mode_we,
  input  logic [MODE_W-1:0]     rounding_mode,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DATA_WIDTH-1:0] quotient,
  input  logic [DATA_WIDTH-1:0] remainder,
  input  logic [ERR_W-1:0]      error_code,
  output int                    pending,
  output int                    failures
);

  localparam int unsigned W = DATA_WIDTH;
  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [W-1:0] quo;
    logic [W-1:0] rem;
    err_t         err;
  } division_t;

  division_t expected_divisions[$];
  mode_t     mode_cfg = MODE_TRUNC;
  int        fail_total = 0;

  // magnitude divide, then fix up quotient and remainder per mode
  function automatic division_t round_divide(input mode_t mode, input logic [W-1:0] ua,
                                             input logic [W-1:0] ub);
    division_t    res;
    logic [W-1:0] ma, mb, qm, rm, q, r, rfm;
    logic         na, nb, adj;
    res = '{quo: '0, rem: '0, err: ERR_NONE};
    if (ub == '0) begin
      res.err = ERR_DIV_ZERO;
      return res;
    end
    if (ua == MIN_VAL && ub == '1) begin
      res.err = ERR_OVERFLOW;
      return res;
    end
    na = ua[W-1];
    nb = ub[W-1];
    ma = na ? -ua : ua;
    mb = nb ? -ub : ub;
    qm = ma / mb;
    rm = ma % mb;
    q  = (na != nb) ? -qm : qm;
    r  = na ? -rm : rm;
    case (mode)
      MODE_FLOOR: begin
        if (rm != '0 && na != nb) begin
          q = q - 1'b1;
          r = r + ub;
        end
      end
      MODE_EUCLID: begin
        if (rm != '0 && na) begin
          if (!nb) begin
            q = q - 1'b1;
            r = r + ub;
          end else begin
            q = q + 1'b1;
            r = r - ub;
          end
        end
      end
      MODE_NONPOS: begin
        if (rm != '0 && !na) begin
          if (!nb) begin
            q = q + 1'b1;
            r = r - ub;
          end else begin
            q = q - 1'b1;
            r = r + ub;
          end
        end
      end
      MODE_NEAREST: begin
        // go to floor first, then step up when past the half point
        adj = (rm != '0) && (na != nb);
        if (adj) begin
          q = q - 1'b1;
          r = r + ub;
        end
        rfm = adj ? (mb - rm) : rm;
        if (rfm > mb - rfm) begin
          q = q + 1'b1;
          r = r - ub;
        end
      end
      default: ;
    endcase
    res.quo = q;
    res.rem = r;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    division_t seen, want;
    if (rst) begin
      expected_divisions.delete();
      mode_cfg = MODE_TRUNC;
    end else begin
      if (in_valid && !in_stall)
        expected_divisions.push_back(round_divide(mode_cfg, dividend, divisor));
      if (out_valid && !out_stall) begin
        seen = '{quo: quotient, rem: remainder, err: error_code};
        if (expected_divisions.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: unexpected result beat q=%0d r=%0d err=%0d", $realtime,
                     $signed(seen.quo), $signed(seen.rem), seen.err);
        end else begin
          want = expected_divisions.pop_front();
          if (seen.quo != want.quo || seen.rem != want.rem || seen.err != want.err) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("%0t: result mismatch exp q=%0d r=%0d err=%0d got q=%0d r=%0d err=%0d",
                       $realtime, $signed(want.quo), $signed(want.rem), want.err,
                       $signed(seen.quo), $signed(seen.rem), seen.err);
          end
        end
      end
      if (rounding_mode_we)
        mode_cfg = rounding_mode;
    end
    pending  <= expected_divisions.size();
    failures <= fail_total;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for signed_divider_rounding_modes_core
// The run steps through every rounding mode code, spare codes included.
// Each phase sends a directed corner set and then random operand pairs in
// bursts, while the result side stalls on its own pattern. The result
// checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_top;
  import sdrm_pkg::*;

  localparam int DW         = 32;
  localparam int LATENCY    = DW + 2;   // accept edge to out_valid
  localparam int PHASES     = 10;
  localparam int RAND_BEATS = 70;       // random beats per phase
  localparam int DIR_BEATS  = 25;
  localparam int LONG_HOLD  = 160;      // longer than the pipeline is deep
  localparam int TIMEOUT_NS = 2_000_000;

  // codes 5..7 carry no rounding rule of their own and must act as truncation
  localparam mode_t MODE_SPARE_5 = 3'd5;
  localparam mode_t MODE_SPARE_6 = 3'd6;
  localparam mode_t MODE_SPARE_7 = 3'd7;

  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] DMAX = ~DMIN;

  logic                 clk;
  logic                 rst;
  logic                 rounding_mode_we;
  mode_t                rounding_mode;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [DW-1:0] dividend;
  logic signed [DW-1:0] divisor;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] quotient;
  logic signed [DW-1:0] remainder;
  err_t                 error_code;

  int pending;
  int failures;
  int beats_sent = 0;
  int burst_left = 0;
  bit steady_sender = 1'b0;

  // mode sequence: every code once, then the two busiest modes again
  mode_t phase_modes [PHASES] = '{MODE_TRUNC, MODE_FLOOR, MODE_EUCLID, MODE_NONPOS,
                                  MODE_NEAREST, MODE_SPARE_5, MODE_SPARE_6,
                                  MODE_SPARE_7, MODE_NEAREST, MODE_FLOOR};

  // corner set: sign combinations, exact halves for nearest, exact
  // multiples, zero dividend, divide by zero, overflow and the extremes
  logic signed [DW-1:0] dir_dividend [DIR_BEATS] = '{
    7, -7, 7, -7, 5, -5, 5, -5, 8, -8, 6, -6, 0,
    123, DMIN, 0, DMIN, DMIN, DMAX, DMAX, DMIN, DMIN, DMAX, -1, DMIN};
  logic signed [DW-1:0] dir_divisor [DIR_BEATS] = '{
    2, 2, -2, -2, 2, 2, -2, -2, 3, 3, 3, 3, 5,
    0, 0, 0, -1, 1, -1, DMIN, DMIN, DMAX, DMAX, DMIN, -2};

  signed_divider_rounding_modes_core #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .rounding_mode_we (rounding_mode_we),
    .rounding_mode    (rounding_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .dividend         (dividend),
    .divisor          (divisor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .quotient         (quotient),
    .remainder        (remainder),
    .error_code       (error_code)
  );

  sdrm_result_checker #(
    .DATA_WIDTH(DW)
  ) result_check (
    .clk              (clk),
    .rst              (rst),
    .rounding_mode_we (rounding_mode_we),
    .rounding_mode    (rounding_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .dividend         (dividend),
    .divisor          (divisor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .quotient         (quotient),
    .remainder        (remainder),
    .error_code       (error_code),
    .pending          (pending),
    .failures         (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Result-side stall pattern. It runs in segments of random style: no
  // stall, light, heavy or periodic. Twice during the run it holds the
  // output stalled for longer than the pipeline is deep while the sender
  // keeps offering beats, so the pipeline fills and in_stall must rise.
  initial begin : stall_pattern
    int seg_left;
    int style;
    int cyc;
    int hold_left;
    int holds_done;
    int hold_at [2];
    seg_left   = 0;
    style      = 0;
    cyc        = 0;
    hold_left  = 0;
    holds_done = 0;
    hold_at    = '{130, 600};
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (holds_done < 2 && beats_sent >= hold_at[holds_done]) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          style    = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= ((cyc % 8) < 3);
        endcase
      end
    end
  end

  // Offer one operand beat and hold it until it is taken. Bursts of random
  // length come with random gaps between them. Valid is only lowered at
  // the start of a gap, so it never drops and rises in the same step.
  task automatic send_beat(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      if (steady_sender || $urandom_range(0, 2) == 0)
        gap = 0;
      else if ($urandom_range(0, 9) == 0)
        gap = $urandom_range(10, 30);
      else
        gap = $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid <= 1'b1;
    dividend <= a;
    divisor  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent <= beats_sent + 1;
    burst_left--;
  endtask

  // Block until every predicted result has come back. The first edge makes
  // sure that the checker has counted a beat taken at the current edge.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // The mode register may change only with the pipeline empty.
  task automatic write_mode(input mode_t m);
    wait_drained();
    rounding_mode_we <= 1'b1;
    rounding_mode    <= m;
    @(posedge clk);
    rounding_mode_we <= 1'b0;
  endtask

  // Random operand mix. Most of it sits where rounding matters: small
  // divisors, exact halves, exact multiples and operands of random size.
  // The rest is full-range noise, zero divisors and the extreme values.
  task automatic pick_operands(output logic signed [DW-1:0] a,
                               output logic signed [DW-1:0] b);
    int sel;
    int k;
    int half;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      a = $urandom;
      b = $urandom;
    end else if (sel < 45) begin
      a = $urandom >> $urandom_range(0, 31);
      b = $urandom_range(1, 20);
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
    end else if (sel < 65) begin
      // exact half: a = b*k + b/2, sometimes one off either way
      half = $urandom_range(1, 500);
      k    = $urandom_range(0, 100000);
      b    = 2 * half;
      a    = b * k + half + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
    end else if (sel < 85) begin
      a = $urandom >> $urandom_range(0, 31);
      b = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
    end else if (sel < 90) begin
      a = $urandom;
      b = '0;
    end else if (sel < 95) begin
      case ($urandom_range(0, 4))
        0: a = DMIN;
        1: a = DMAX;
        2: a = '0;
        3: a = -1;
        default: a = 1;
      endcase
      case ($urandom_range(0, 5))
        0: b = DMIN;
        1: b = DMAX;
        2: b = -1;
        3: b = 1;
        4: b = 2;
        default: b = -2;
      endcase
    end else begin
      b = $urandom >> $urandom_range(16, 31);
      if (b == '0) b = 1;
      a = b * $signed($urandom >> $urandom_range(1, 31));
      if ($urandom_range(0, 1)) b = -b;
    end
  endtask

  // Main sequence: reset, then per phase a mode write, the corner set and
  // the random beats. Verdict once everything has drained.
  initial begin : stimulus
    logic signed [DW-1:0] a, b;
    rst              <= 1'b1;
    rounding_mode_we <= 1'b0;
    rounding_mode    <= MODE_TRUNC;
    in_valid         <= 1'b0;
    dividend         <= '0;
    divisor          <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      write_mode(phase_modes[p]);
      steady_sender = ($urandom_range(0, 3) == 0);
      burst_left    = 0;
      for (int i = 0; i < DIR_BEATS; i++)
        send_beat(dir_dividend[i], dir_divisor[i]);
      for (int i = 0; i < RAND_BEATS; i++) begin
        pick_operands(a, b);
        send_beat(a, b);
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sdrm_pkg.sv
rtl/signed_divider_rounding_modes_core.sv
rtl/sdrm_checker.sv
dv/sdrm_result_checker.sv
dv/tb_top.sv
